FILE: hw/rtl/mvm_pkg.sv
// Shared types, field widths, operation and register codes for the
// matrix-vector multiplier. No dependencies; used by mvm_intf, mvm_cell and the top level.
`default_nettype none

package mvm_pkg;

    // Fixed field widths of the item, result and configuration channels
    localparam int OP_W       = 2;
    localparam int ROW_IDX_W  = 6;
    localparam int COL_IDX_W  = 6;
    localparam int ELEM_W     = 16;
    localparam int OUT_ROW_W  = 6;
    localparam int DOT_W      = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Defaults for the top-level parameters
    localparam int MAX_ROWS_DEF   = 64;
    localparam int MAX_COLS_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 16;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_WR_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_VECTOR = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  CFG_ROWS_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_COLS_USED = 1'd1;
    localparam logic [CFG_DATA_W-1:0] ROWS_USED_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] COLS_USED_RST = 7'd64;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic clear;   // zero the accumulator at the start of a compute
        logic shift;   // take the right neighbour's accumulator
        logic wr_en;   // weight write, column already range-checked
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: hw/rtl/mvm_intf.sv
// Channel interfaces: input items, result items and configuration writes.
// Depends on mvm_pkg for the field widths.
`default_nettype none

interface mvm_item_if;
    logic                          valid;
    logic                          ready;
    logic [mvm_pkg::OP_W-1:0]      op;
    logic [mvm_pkg::ROW_IDX_W-1:0] row_index;
    logic [mvm_pkg::COL_IDX_W-1:0] col_index;
    logic signed [mvm_pkg::ELEM_W-1:0] element;

    modport source (output valid, op, row_index, col_index, element, input ready);
    modport sink   (input valid, op, row_index, col_index, element, output ready);
endinterface

interface mvm_result_if;
    logic                          valid;
    logic                          ready;
    logic [mvm_pkg::OUT_ROW_W-1:0] out_row;
    logic signed [mvm_pkg::DOT_W-1:0] dot_value;
    logic                          last_row;

    modport source (output valid, out_row, dot_value, last_row, input ready);
    modport sink   (input valid, out_row, dot_value, last_row, output ready);
endinterface

interface mvm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mvm_pkg::CFG_IDX_W-1:0]  index;
    logic [mvm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mvm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/mvm_cell.sv
// One row cell: weight memory for its row, multiply-accumulate pipeline,
// and a registered hop of the vector token to the next cell. Uses mvm_pkg, mvm_ram.
`default_nettype none

module mvm_cell #(
    parameter int ROW        = 0,
    parameter int MAX_COLS   = mvm_pkg::MAX_COLS_DEF,
    parameter int ELEM_WIDTH = mvm_pkg::ELEM_WIDTH_DEF,
    localparam int COL_AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mvm_pkg::t_cell_ctl                 i_ctl,
    input  wire logic [mvm_pkg::ROW_IDX_W-1:0]      i_wr_row,
    input  wire logic [COL_AW-1:0]                  i_wr_col,
    input  wire logic [ELEM_WIDTH-1:0]              i_wr_data,
    input  wire logic                               i_tok_valid,
    input  wire logic [COL_AW-1:0]                  i_tok_col,
    input  wire logic signed [ELEM_WIDTH-1:0]       i_tok_vec,
    output logic                                    o_tok_valid,
    output logic [COL_AW-1:0]                       o_tok_col,
    output logic signed [ELEM_WIDTH-1:0]            o_tok_vec,
    input  wire logic signed [mvm_pkg::DOT_W-1:0]   i_acc_next,
    output logic signed [mvm_pkg::DOT_W-1:0]        o_acc
);

    logic                              we;
    logic [ELEM_WIDTH-1:0]             wt_rdata;
    logic signed [ELEM_WIDTH-1:0]      wt;
    logic                              r_a_valid;
    logic [COL_AW-1:0]                 r_a_col;
    logic signed [ELEM_WIDTH-1:0]      r_a_vec;
    logic                              r_p_valid;
    logic signed [2*ELEM_WIDTH-1:0]    r_p;
    logic signed [2*ELEM_WIDTH-1:0]    n_p;
    logic signed [mvm_pkg::DOT_W-1:0]  r_acc;

    // Weight write targets this row only
    assign we = i_ctl.wr_en && (32'(i_wr_row) == ROW);

    mvm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_wr_col),
        .i_wdata (i_wr_data),
        .i_raddr (i_tok_col),
        .o_rdata (wt_rdata)
    );

    assign wt  = signed'(wt_rdata);
    assign n_p = wt * r_a_vec;

    // Token and product stages: line the vector element up with the weight read, then register the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            r_a_valid <= i_tok_valid;
            r_p_valid <= r_a_valid;
        end
        r_a_col <= i_tok_col;
        r_a_vec <= i_tok_vec;
        r_p     <= n_p;
    end

    // Accumulator: clear, shift towards row 0, or add the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= i_acc_next;
        end else if (r_p_valid) begin
            r_acc <= r_acc + mvm_pkg::DOT_W'(r_p);
        end
    end

    assign o_tok_valid = r_a_valid;
    assign o_tok_col   = r_a_col;
    assign o_tok_vec   = r_a_vec;
    assign o_acc       = r_acc;

endmodule

`default_nettype wire

FILE: hw/rtl/matrix_vector_multiply.sv
// Top level of the matrix-vector multiplier: controller, vector memory and
// the chain of row cells. Uses mvm_pkg, mvm_intf, mvm_ram and mvm_cell.
//
// Usage:
//   i_item  : items carry op, row_index, col_index and element. Weight and
//             vector writes stream back to back while the controller is idle.
//   i_cfg   : writes rows_used (index 0) or cols_used (index 1); always ready,
//             to be used only while no compute is in progress.
//   o_result: one transfer per row in use, rows in ascending order, with
//             last_row set on the final one.
// A compute item runs the vector down the cell chain: one column enters per
// cycle and each cell registers it before passing it on, so the length of
// the run is set by the column count and the length of the chain. The results
// then leave one per cycle from cell 0, the accumulators shifting towards it
// on each transfer; a stalled receiver simply holds the chain. The item
// channel is not ready from a compute until its last result is taken.
// Reset sets rows_used and cols_used to 64 and returns to idle; the weight
// and vector memories are not cleared and hold nothing until written.
`default_nettype none

module matrix_vector_multiply #(
    parameter int MAX_ROWS   = mvm_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = mvm_pkg::MAX_COLS_DEF,
    parameter int ELEM_WIDTH = mvm_pkg::ELEM_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    mvm_cfg_if.sink        i_cfg,
    mvm_item_if.sink       i_item,
    mvm_result_if.source   o_result
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NC_W   = $clog2(MAX_COLS + 1);
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = $clog2(MAX_COLS + MAX_ROWS + 3);

    mvm_pkg::t_state                     r_state, n_state;
    logic [CNT_W-1:0]                    r_cnt, n_cnt;
    logic [NR_W-1:0]                     r_out_cnt, n_out_cnt;
    logic [mvm_pkg::CFG_DATA_W-1:0]      r_rows_used, r_cols_used;
    logic [NR_W-1:0]                     n_rows;
    logic [NC_W-1:0]                     n_cols;
    logic [CNT_W-1:0]                    run_end;
    logic                                item_xfer, out_xfer, cfg_xfer;
    logic                                col_ok, vec_we, issue, last;
    logic signed [ELEM_WIDTH-1:0]        elem;
    logic [COL_AW-1:0]                   wr_col;
    logic [ELEM_WIDTH-1:0]               vec_rdata;
    logic                                r_tok_valid;
    logic [COL_AW-1:0]                   r_tok_col;
    mvm_pkg::t_cell_ctl                  ctl;

    logic                                tok_valid [MAX_ROWS+1];
    logic [COL_AW-1:0]                   tok_col   [MAX_ROWS+1];
    logic signed [ELEM_WIDTH-1:0]        tok_vec   [MAX_ROWS+1];
    logic signed [mvm_pkg::DOT_W-1:0]    acc       [MAX_ROWS+1];

    // Handshakes
    assign item_xfer = i_item.valid && i_item.ready;
    assign out_xfer  = o_result.valid && o_result.ready;
    assign cfg_xfer  = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == mvm_pkg::ST_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= mvm_pkg::ROWS_USED_RST;
            r_cols_used <= mvm_pkg::COLS_USED_RST;
        end else if (cfg_xfer) begin
            case (i_cfg.index)
                mvm_pkg::CFG_ROWS_USED: r_rows_used <= i_cfg.data;
                mvm_pkg::CFG_COLS_USED: r_cols_used <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Dimensions clamped to the built size
    assign n_rows = (32'(r_rows_used) > MAX_ROWS) ? NR_W'(MAX_ROWS) : NR_W'(r_rows_used);
    assign n_cols = (32'(r_cols_used) > MAX_COLS) ? NC_W'(MAX_COLS) : NC_W'(r_cols_used);
    assign run_end = CNT_W'(n_cols) + CNT_W'(MAX_ROWS + 2);

    // Write data and address; the element bits are taken as raw field bits
    assign elem   = ELEM_WIDTH'($unsigned(i_item.element));
    assign wr_col = COL_AW'(i_item.col_index);
    assign col_ok = (32'(i_item.col_index) < MAX_COLS);

    // Next state and broadcast control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_cnt = r_out_cnt;
        ctl       = '0;
        vec_we    = 1'b0;
        case (r_state)
            mvm_pkg::ST_IDLE: begin
                if (item_xfer) begin
                    case (i_item.op)
                        mvm_pkg::OP_WR_WEIGHT: ctl.wr_en = col_ok;
                        mvm_pkg::OP_WR_VECTOR: vec_we = col_ok;
                        mvm_pkg::OP_COMPUTE: begin
                            ctl.clear = 1'b1;
                            n_cnt     = '0;
                            n_state   = mvm_pkg::ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            mvm_pkg::ST_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == run_end) begin
                    n_out_cnt = '0;
                    n_state   = (n_rows == '0) ? mvm_pkg::ST_IDLE : mvm_pkg::ST_DRAIN;
                end
            end
            mvm_pkg::ST_DRAIN: begin
                if (out_xfer) begin
                    ctl.shift = 1'b1;
                    n_out_cnt = r_out_cnt + 1'b1;
                    if (last) begin
                        n_state = mvm_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = mvm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt     <= n_cnt;
        r_out_cnt <= n_out_cnt;
    end

    // Vector read issue: one column per cycle at the head of the run
    assign issue = (r_state == mvm_pkg::ST_RUN) && (r_cnt < CNT_W'(n_cols));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= issue;
        end
        r_tok_col <= COL_AW'(r_cnt);
    end

    mvm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_COLS)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (wr_col),
        .i_wdata (elem),
        .i_raddr (COL_AW'(r_cnt)),
        .o_rdata (vec_rdata)
    );

    // Head and tail of the chain
    assign tok_valid[0]  = r_tok_valid;
    assign tok_col[0]    = r_tok_col;
    assign tok_vec[0]    = signed'(vec_rdata);
    assign acc[MAX_ROWS] = '0;

    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
        mvm_cell #(
            .ROW        (g),
            .MAX_COLS   (MAX_COLS),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_wr_row    (i_item.row_index),
            .i_wr_col    (wr_col),
            .i_wr_data   (elem),
            .i_tok_valid (tok_valid[g]),
            .i_tok_col   (tok_col[g]),
            .i_tok_vec   (tok_vec[g]),
            .o_tok_valid (tok_valid[g+1]),
            .o_tok_col   (tok_col[g+1]),
            .o_tok_vec   (tok_vec[g+1]),
            .i_acc_next  (acc[g+1]),
            .o_acc       (acc[g])
        );
    end

    // Result channel, fed from cell 0
    assign last               = (r_out_cnt == NR_W'(n_rows - 1'b1));
    assign o_result.valid     = (r_state == mvm_pkg::ST_DRAIN);
    assign o_result.out_row   = mvm_pkg::OUT_ROW_W'(r_out_cnt);
    assign o_result.dot_value = acc[0];
    assign o_result.last_row  = last;

endmodule

`default_nettype wire
